FILE: rtl/core/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared operation codes and the command/status bundles passed between the
// collector controller and its datapath.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_COLLECT = 2'd2;

    // Most result beats one collect run reports
    localparam int MAX_RESULTS = 8;

    typedef struct packed {
        logic host_write;   // store links of the input entry, set it allocated
        logic host_read;    // latch input entry, read its links
        logic start;        // latch roots, rewind sweep pointer
        logic try_root;     // mark and push the selected root if visitable
        logic root_sel_b;   // select second root
        logic fetch;        // read links of stack top
        logic examine;      // push first visitable child or pop
        logic load_top;     // take new stack top from stack read data
        logic sweep_read;   // read links of sweep entry
        logic sweep_step;   // free/report/unmark sweep entry, advance
        logic read_emit;    // load read result into output register
    } msc_cmd_t;

    typedef struct packed {
        logic root_ok;
        logic child_found;
        logic depth_one;
        logic sweep_last;
        logic step_ok;
        logic out_free;
    } msc_sts_t;

endpackage

FILE: rtl/core/msc_datapath.sv
// ----------------------------------------------------------------------------
// msc_datapath
// Heap table storage (allocated bits, reach marks, link memory), the walk
// stack memory and the output register of the mark-and-sweep collector.
// ----------------------------------------------------------------------------
module msc_datapath #(
    parameter int HEAP_ENTRIES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  msc_pkg::msc_cmd_t cmd,
    output msc_pkg::msc_sts_t sts,
    input  logic [2:0]        entry_index,
    input  logic [3:0]        first_link,
    input  logic [3:0]        second_link,
    input  logic [3:0]        third_link,
    input  logic [3:0]        root_a,
    input  logic [3:0]        root_b,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        result_index,
    output logic              is_allocated,
    output logic              was_freed,
    output logic [3:0]        out_first_link,
    output logic [3:0]        out_second_link,
    output logic [3:0]        out_third_link,
    output logic              last_result
);

    localparam int IW  = $clog2(HEAP_ENTRIES);
    localparam int LW  = $clog2(HEAP_ENTRIES + 1);
    localparam int DW  = $clog2(HEAP_ENTRIES + 1);
    localparam int RES = (HEAP_ENTRIES < msc_pkg::MAX_RESULTS) ?
                         HEAP_ENTRIES : msc_pkg::MAX_RESULTS;
    localparam logic [LW-1:0] NULL_LINK = LW'(HEAP_ENTRIES);

    function automatic logic [LW-1:0] norm_link(input logic [3:0] v);
        return (int'(v) < HEAP_ENTRIES) ? LW'(v) : NULL_LINK;
    endfunction

    // Control state
    logic [HEAP_ENTRIES-1:0] alloc_reg;
    logic [HEAP_ENTRIES-1:0] mark_reg;
    logic [DW-1:0]           depth_reg;
    logic                    out_valid_reg;

    // Payload
    logic [3*LW-1:0] link_mem [HEAP_ENTRIES];
    logic [3*LW-1:0] link_rdata_reg;
    logic [IW-1:0]   stack_mem [HEAP_ENTRIES];
    logic [IW-1:0]   stack_rdata_reg;
    logic [IW-1:0]   top_reg;
    logic [IW-1:0]   cur_reg;
    logic [IW-1:0]   sweep_reg;
    logic [LW-1:0]   root_a_reg;
    logic [LW-1:0]   root_b_reg;
    logic [2:0]      res_index_reg;
    logic            res_alloc_reg;
    logic            res_freed_reg;
    logic [LW-1:0]   res_link_reg [3];
    logic            res_last_reg;

    logic [2:0]      idx_wrap;
    logic [IW-1:0]   host_idx;
    logic [LW-1:0]   child [3];
    logic [LW-1:0]   root_sel;
    logic            root_ok;
    logic            child_found;
    logic [IW-1:0]   child_idx;
    logic [DW-1:0]   depth_m2;
    logic            sweep_free;
    logic            sweep_emit;
    logic            out_free;
    logic            out_load;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    logic [3*LW-1:0] mem_wdata;
    logic            mem_re;
    logic [IW-1:0]   mem_raddr;
    logic            stk_we;
    logic [IW-1:0]   stk_waddr;
    logic [IW-1:0]   stk_wdata;
    logic            pop;

    // Wrap entry index into the table by repeated subtraction
    always_comb
    begin
        idx_wrap = entry_index;
        for (int i = 0; i < 4; i++)
        begin
            if (int'(idx_wrap) >= HEAP_ENTRIES)
            begin
                idx_wrap = idx_wrap - 3'(HEAP_ENTRIES);
            end
        end
        host_idx = IW'(idx_wrap);
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            child[k] = link_rdata_reg[k*LW +: LW];
        end
    end

    assign root_sel = cmd.root_sel_b ? root_b_reg : root_a_reg;
    assign root_ok  = (int'(root_sel) < HEAP_ENTRIES) &&
                      alloc_reg[root_sel[IW-1:0]] && !mark_reg[root_sel[IW-1:0]];

    // First visitable child in link order wins
    always_comb
    begin
        child_found = 1'b0;
        child_idx   = '0;
        for (int k = 2; k >= 0; k--)
        begin
            if ((int'(child[k]) < HEAP_ENTRIES) && alloc_reg[child[k][IW-1:0]] &&
                !mark_reg[child[k][IW-1:0]] && (int'(depth_reg) < HEAP_ENTRIES))
            begin
                child_found = 1'b1;
                child_idx   = child[k][IW-1:0];
            end
        end
    end

    assign depth_m2   = depth_reg - DW'(2);
    assign pop        = cmd.examine && !child_found;
    assign sweep_free = alloc_reg[sweep_reg] && !mark_reg[sweep_reg];
    assign sweep_emit = int'(sweep_reg) < RES;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_load   = cmd.read_emit || (cmd.sweep_step && sweep_emit);

    assign sts.root_ok     = root_ok;
    assign sts.child_found = child_found;
    assign sts.depth_one   = (depth_reg == DW'(1));
    assign sts.sweep_last  = (sweep_reg == IW'(HEAP_ENTRIES - 1));
    assign sts.step_ok     = out_free || !sweep_emit;
    assign sts.out_free    = out_free;

    // Link memory ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = host_idx;
        mem_wdata = {norm_link(third_link), norm_link(second_link),
                     norm_link(first_link)};
        if (cmd.host_write)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.sweep_step && sweep_free)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = {NULL_LINK, NULL_LINK, NULL_LINK};
        end
    end

    always_comb
    begin
        mem_re    = cmd.host_read || cmd.fetch || cmd.sweep_read;
        mem_raddr = host_idx;
        if (cmd.fetch)
        begin
            mem_raddr = top_reg;
        end
        else if (cmd.sweep_read)
        begin
            mem_raddr = sweep_reg;
        end
    end

    // Stack memory ports
    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = root_sel[IW-1:0];
        if (cmd.try_root && root_ok)
        begin
            stk_we = 1'b1;
        end
        else if (cmd.examine && child_found)
        begin
            stk_we    = 1'b1;
            stk_waddr = depth_reg[IW-1:0];
            stk_wdata = child_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            link_rdata_reg <= link_mem[mem_raddr];
        end
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (pop)
        begin
            stack_rdata_reg <= stack_mem[depth_m2[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg     <= '0;
            mark_reg      <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.host_write)
            begin
                alloc_reg[host_idx] <= 1'b1;
            end
            if (cmd.sweep_step)
            begin
                if (sweep_free)
                begin
                    alloc_reg[sweep_reg] <= 1'b0;
                end
                mark_reg[sweep_reg] <= 1'b0;
            end
            if (cmd.try_root && root_ok)
            begin
                mark_reg[root_sel[IW-1:0]] <= 1'b1;
                depth_reg                  <= DW'(1);
            end
            if (cmd.examine)
            begin
                if (child_found)
                begin
                    mark_reg[child_idx] <= 1'b1;
                    depth_reg           <= depth_reg + DW'(1);
                end
                else
                begin
                    depth_reg <= depth_reg - DW'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.host_read)
        begin
            cur_reg <= host_idx;
        end
        if (cmd.start)
        begin
            root_a_reg <= norm_link(root_a);
            root_b_reg <= norm_link(root_b);
            sweep_reg  <= '0;
        end
        else if (cmd.sweep_step)
        begin
            sweep_reg <= sweep_reg + IW'(1);
        end
        if (cmd.try_root && root_ok)
        begin
            top_reg <= root_sel[IW-1:0];
        end
        else if (cmd.examine && child_found)
        begin
            top_reg <= child_idx;
        end
        else if (cmd.load_top)
        begin
            top_reg <= stack_rdata_reg;
        end
        if (cmd.read_emit)
        begin
            res_index_reg <= 3'(cur_reg);
            res_alloc_reg <= alloc_reg[cur_reg];
            res_freed_reg <= 1'b0;
            res_last_reg  <= 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                res_link_reg[k] <= child[k];
            end
        end
        else if (cmd.sweep_step && sweep_emit)
        begin
            res_index_reg <= 3'(sweep_reg);
            res_alloc_reg <= alloc_reg[sweep_reg] && mark_reg[sweep_reg];
            res_freed_reg <= sweep_free;
            res_last_reg  <= (int'(sweep_reg) == RES - 1);
            for (int k = 0; k < 3; k++)
            begin
                res_link_reg[k] <= sweep_free ? NULL_LINK : child[k];
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_index    = res_index_reg;
    assign is_allocated    = res_alloc_reg;
    assign was_freed       = res_freed_reg;
    assign out_first_link  = 4'(res_link_reg[0]);
    assign out_second_link = 4'(res_link_reg[1]);
    assign out_third_link  = 4'(res_link_reg[2]);
    assign last_result     = res_last_reg;

endmodule

FILE: rtl/core/msc_controller.sv
// ----------------------------------------------------------------------------
// msc_controller
// Sequences write, read and collect operations: root tries, the depth-first
// walk on the stack, then the sweep over all entries.
// ----------------------------------------------------------------------------
module msc_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    output msc_pkg::msc_cmd_t cmd,
    input  msc_pkg::msc_sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_EMIT,
        S_ROOT_A,
        S_ROOT_B,
        S_FETCH,
        S_EXAMINE,
        S_POP,
        S_SW_RD,
        S_SW_STEP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   walk_b_reg;
    logic   walk_b_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.host_write = accept && (operation == msc_pkg::OP_WRITE);
        cmd.host_read  = accept && (operation == msc_pkg::OP_READ);
        cmd.start      = accept && (operation == msc_pkg::OP_COLLECT);
        cmd.try_root   = (state_reg == S_ROOT_A) || (state_reg == S_ROOT_B);
        cmd.root_sel_b = (state_reg == S_ROOT_B);
        cmd.fetch      = (state_reg == S_FETCH);
        cmd.examine    = (state_reg == S_EXAMINE);
        cmd.load_top   = (state_reg == S_POP);
        cmd.sweep_read = (state_reg == S_SW_RD);
        cmd.sweep_step = (state_reg == S_SW_STEP) && sts.step_ok;
        cmd.read_emit  = (state_reg == S_RD_EMIT) && sts.out_free;
    end

    always_comb
    begin
        state_next  = state_reg;
        walk_b_next = walk_b_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.host_read)
                begin
                    state_next = S_RD_EMIT;
                end
                else if (cmd.start)
                begin
                    state_next = S_ROOT_A;
                end
            end
            S_RD_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROOT_A:
            begin
                walk_b_next = 1'b0;
                state_next  = sts.root_ok ? S_FETCH : S_ROOT_B;
            end
            S_ROOT_B:
            begin
                walk_b_next = 1'b1;
                state_next  = sts.root_ok ? S_FETCH : S_SW_RD;
            end
            S_FETCH:
            begin
                state_next = S_EXAMINE;
            end
            S_EXAMINE:
            begin
                if (sts.child_found)
                begin
                    state_next = S_FETCH;
                end
                else if (sts.depth_one)
                begin
                    // stack empties: walk from next root or start the sweep
                    state_next = walk_b_reg ? S_SW_RD : S_ROOT_B;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                state_next = S_FETCH;
            end
            S_SW_RD:
            begin
                state_next = S_SW_STEP;
            end
            S_SW_STEP:
            begin
                if (sts.step_ok)
                begin
                    state_next = sts.sweep_last ? S_IDLE : S_SW_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            walk_b_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            walk_b_reg <= walk_b_next;
        end
    end

endmodule

FILE: rtl/core/mark_sweep_collector_top.sv
// ----------------------------------------------------------------------------
// mark_sweep_collector_top
// Mark-and-sweep collector over a table of HEAP_ENTRIES three-link objects.
// ----------------------------------------------------------------------------
// One item is in work at a time; in_ready is high only while the block is
// idle. A write gives no result. A read gives one result beat. A collect
// tries the two roots in turn and walks depth first from each one that is
// allocated and unmarked (fetch and examine of the stack top on the single
// link memory read port, plus a stack read on each pop), then sweeps every
// entry with a read and a step. The read and the sweep can stall while the
// output side holds a beat. The sweep reports one beat per entry for the
// first min(HEAP_ENTRIES, 8) entries, the last one flagged by last_result.
// The output register lets the next item be taken while the final beat
// still waits. Unused operation code 3 is taken and ignored; links or roots
// outside the table count as null.
// ----------------------------------------------------------------------------
module mark_sweep_collector_top #(
    parameter int HEAP_ENTRIES = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [2:0] entry_index,
    input  logic [3:0] first_link,
    input  logic [3:0] second_link,
    input  logic [3:0] third_link,
    input  logic [3:0] root_a,
    input  logic [3:0] root_b,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] result_index,
    output logic       is_allocated,
    output logic       was_freed,
    output logic [3:0] out_first_link,
    output logic [3:0] out_second_link,
    output logic [3:0] out_third_link,
    output logic       last_result
);

    msc_pkg::msc_cmd_t cmd;
    msc_pkg::msc_sts_t sts;

    msc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .cmd       (cmd),
        .sts       (sts)
    );

    msc_datapath #(
        .HEAP_ENTRIES (HEAP_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .entry_index     (entry_index),
        .first_link      (first_link),
        .second_link     (second_link),
        .third_link      (third_link),
        .root_a          (root_a),
        .root_b          (root_b),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_index    (result_index),
        .is_allocated    (is_allocated),
        .was_freed       (was_freed),
        .out_first_link  (out_first_link),
        .out_second_link (out_second_link),
        .out_third_link  (out_third_link),
        .last_result     (last_result)
    );

endmodule

FILE: rtl/core/msc_checker.sv
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks of the collector, attached to the top level by bind.
// ----------------------------------------------------------------------------
module msc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] operation,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] result_index,
    input logic       is_allocated,
    input logic       was_freed,
    input logic [3:0] out_first_link,
    input logic       last_result
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_index) &&
        $stable(out_first_link) && $stable(last_result))
        else $error("stalled result beat changed");

    // Read and collect occupy the block for at least the next cycle
    a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
        (operation == msc_pkg::OP_READ || operation == msc_pkg::OP_COLLECT)
        |=> !in_ready)
        else $error("block ready right after read or collect");

    // Write and the unused code finish in the cycle they are taken
    a_ready_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation != msc_pkg::OP_READ &&
        operation != msc_pkg::OP_COLLECT |=> in_ready)
        else $error("block busy after write");

    // A freed entry is never reported live
    a_freed_not_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_freed && is_allocated))
        else $error("entry both freed and allocated");

endmodule

bind mark_sweep_collector_top msc_checker u_msc_checker (.*);
